[design/dptk_pkg.sv]
// dptk_pkg: shared types and constants for the dot-product top-k ranker
`default_nettype none

package dptk_pkg;

	// operation codes carried in the input tuser
	localparam logic [1:0] OP_QUERY     = 2'd0;
	localparam logic [1:0] OP_CANDIDATE = 2'd1;
	localparam logic [1:0] OP_EMIT      = 2'd2;

	// configuration register indexes
	localparam logic CFG_DIMENSION = 1'b0;
	localparam logic CFG_KEEP      = 1'b1;

	// field widths
	localparam int unsigned DIM_W   = 10;
	localparam int unsigned KEEP_W  = 5;
	localparam int unsigned EIDX_W  = 9;
	localparam int unsigned VAL_W   = 32;
	localparam int unsigned RANK_W  = 4;
	localparam int unsigned CIDX_W  = 12;
	localparam int unsigned SCORE_W = 64;
	localparam int unsigned IN_TDATA_W  = 48;
	localparam int unsigned OUT_TDATA_W = 88;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ACC,
		ST_INS,
		ST_EMIT
	} state_t;

endpackage

`default_nettype wire

[design/dot_product_top_k_ranker.sv]
// dot_product_top_k_ranker: query store, shared multiply-accumulate and top-k insertion sequencer
//
// Load the query with operation 0 (one component per transfer), stream candidate components
// with operation 1, then send operation 2 to read out the best keep_count candidates in rank
// order, best first, equal scores in arrival order. A candidate component passes through query
// memory read, 32x32 multiply and saturating 64-bit accumulate. On a candidate's final
// component the score is then placed into the sorted list by a single compare unit that walks
// the list from the tail, one entry per cycle. An end transfer reads the ranks out in order and
// waits while the output is stalled. s_tready is high only between items. No clearing pass is
// needed after reset.
`default_nettype none

module dot_product_top_k_ranker #(
	parameter int unsigned MAX_DIM        = 512,
	parameter int unsigned MAX_KEEP       = 16,
	parameter int unsigned MAX_CANDIDATES = 4096
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// input stream
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// s_tdata: element_index [8:0], component_value [40:9], zeros above
	input  wire logic [dptk_pkg::IN_TDATA_W-1:0]   s_tdata,
	// s_tuser: operation [1:0]
	input  wire logic [1:0]                        s_tuser,
	// result stream
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// m_tdata: rank [3:0], candidate_index [15:4], score [79:16], overflow [80], zeros above
	output logic [dptk_pkg::OUT_TDATA_W-1:0]       m_tdata,
	output logic                                   m_tlast,
	// configuration writes
	input  wire logic                              cfg_we,
	input  wire logic                              cfg_index,
	input  wire logic [dptk_pkg::DIM_W-1:0]        cfg_data
);
	import dptk_pkg::*;

	localparam int unsigned AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int unsigned KW = $clog2(MAX_KEEP + 1);
	localparam int unsigned IW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
	localparam int unsigned CW = $clog2(MAX_CANDIDATES + 1);

	// configuration registers
	logic [DIM_W-1:0]  dim_q;
	logic [KEEP_W-1:0] keep_q;

	// sequencer
	state_t state_q, state_d;

	// query memory and first stage
	logic [VAL_W-1:0]         qmem [MAX_DIM];
	logic signed [VAL_W-1:0]  q_s1;
	logic signed [VAL_W-1:0]  val_s1;
	logic                     qok_s1;
	logic                     last_s1;

	// product stage
	logic signed [SCORE_W-1:0] prod_s2;
	logic                      last_s2;

	// run state
	logic signed [SCORE_W-1:0] acc_q;
	logic [CW-1:0]             cnt_q;
	logic                      ovf_q;
	logic [KW-1:0]             fill_q;

	// best list
	logic signed [SCORE_W-1:0] best_score_q [MAX_KEEP];
	logic [CIDX_W-1:0]         best_idx_q [MAX_KEEP];

	// insertion walk
	logic signed [SCORE_W-1:0] new_score_q;
	logic [CIDX_W-1:0]         new_idx_q;
	logic [KW-1:0]             ins_i_q;

	// readout
	logic [KW-1:0] rank_q;

	// output register
	logic                      out_valid_q;
	logic [RANK_W-1:0]         out_rank_q;
	logic [CIDX_W-1:0]         out_idx_q;
	logic signed [SCORE_W-1:0] out_score_q;
	logic                      out_ovf_q;
	logic                      out_last_q;

	// input field decode
	logic [1:0]           in_op;
	logic [EIDX_W-1:0]    in_ei;
	logic [VAL_W-1:0]     in_val;
	logic                 in_fire;
	logic                 ei_in_range;
	logic [AW-1:0]        q_addr;

	assign in_op       = s_tuser;
	assign in_ei       = s_tdata[EIDX_W-1:0];
	assign in_val      = s_tdata[EIDX_W+VAL_W-1:EIDX_W];
	assign in_fire     = s_tvalid && s_tready;
	assign ei_in_range = int'(in_ei) < MAX_DIM;
	assign q_addr      = AW'(in_ei);

	// clamped configuration
	logic [DIM_W-1:0] dim_eff;
	logic [KW-1:0]    keep_eff;
	logic [KW-1:0]    n_eff;
	logic             ei_is_last;

	always_comb begin
		if (dim_q == '0) begin
			dim_eff = DIM_W'(1);
		end else if (int'(dim_q) > MAX_DIM) begin
			dim_eff = DIM_W'(MAX_DIM);
		end else begin
			dim_eff = dim_q;
		end
		if (keep_q == '0) begin
			keep_eff = KW'(1);
		end else if (int'(keep_q) > MAX_KEEP) begin
			keep_eff = KW'(MAX_KEEP);
		end else begin
			keep_eff = KW'(keep_q);
		end
		n_eff = (fill_q < keep_eff) ? fill_q : keep_eff;
	end

	assign ei_is_last = {1'b0, in_ei} == (dim_eff - DIM_W'(1));

	// saturating accumulate
	logic [SCORE_W:0]          sum_ext;
	logic signed [SCORE_W-1:0] acc_sat;

	always_comb begin
		sum_ext = {acc_q[SCORE_W-1], acc_q} + {prod_s2[SCORE_W-1], prod_s2};
		if (sum_ext[SCORE_W] != sum_ext[SCORE_W-1]) begin
			acc_sat = sum_ext[SCORE_W] ? {1'b1, {(SCORE_W-1){1'b0}}}
			                           : {1'b0, {(SCORE_W-1){1'b1}}};
		end else begin
			acc_sat = sum_ext[SCORE_W-1:0];
		end
	end

	// single read port of the best list and the shared compare
	logic [IW-1:0]             rd_idx;
	logic signed [SCORE_W-1:0] rd_score;
	logic [CIDX_W-1:0]         rd_cidx;
	logic [IW-1:0]             wr_idx;
	logic                      wr_ok;
	logic                      shift_up;

	always_comb begin
		if (state_q == ST_EMIT) begin
			rd_idx = IW'(rank_q);
		end else begin
			rd_idx = IW'(ins_i_q - KW'(1));
		end
		rd_score = best_score_q[rd_idx];
		rd_cidx  = best_idx_q[rd_idx];
		wr_idx   = IW'(ins_i_q);
		wr_ok    = int'(ins_i_q) < MAX_KEEP;
		shift_up = (ins_i_q != '0) && (rd_score < new_score_q);
	end

	// control decode
	logic cand_ok;
	logic emit_done;
	logic out_load;

	assign cand_ok   = int'(cnt_q) < MAX_CANDIDATES;
	assign emit_done = rank_q == n_eff;
	assign out_load  = (state_q == ST_EMIT) && !emit_done && (!out_valid_q || m_tready);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and handshake
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					case (in_op)
						OP_CANDIDATE: state_d = ST_MUL;
						OP_EMIT:      state_d = ST_EMIT;
						default:      state_d = ST_IDLE;
					endcase
				end
			end
			ST_MUL: begin
				state_d = ST_ACC;
			end
			ST_ACC: begin
				state_d = (last_s2 && cand_ok) ? ST_INS : ST_IDLE;
			end
			ST_INS: begin
				if (!shift_up) begin
					state_d = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (emit_done) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q  <= DIM_W'(512);
			keep_q <= KEEP_W'(10);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DIMENSION: dim_q  <= cfg_data;
				CFG_KEEP:      keep_q <= cfg_data[KEEP_W-1:0];
				default: ;
			endcase
		end
	end

	// query memory write and registered read
	always_ff @(posedge clk) begin
		if (in_fire && in_op == OP_QUERY && ei_in_range) begin
			qmem[q_addr] <= in_val;
		end
		if (in_fire) begin
			q_s1 <= qmem[q_addr];
		end
	end

	// first and second stage payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			val_s1  <= in_val;
			qok_s1  <= ei_in_range;
			last_s1 <= ei_is_last;
		end
		if (state_q == ST_MUL) begin
			prod_s2 <= qok_s1 ? SCORE_W'(q_s1 * val_s1) : '0;
			last_s2 <= last_s1;
		end
	end

	// run state: accumulator, candidate counter, overflow flag, fill, walk and readout counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			fill_q  <= '0;
			ins_i_q <= '0;
			rank_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					rank_q <= '0;
				end
				ST_ACC: begin
					if (last_s2) begin
						acc_q <= '0;
						if (cand_ok) begin
							cnt_q   <= cnt_q + CW'(1);
							ins_i_q <= fill_q;
						end else begin
							ovf_q <= 1'b1;
						end
					end else begin
						acc_q <= acc_sat;
					end
				end
				ST_INS: begin
					if (shift_up) begin
						ins_i_q <= ins_i_q - KW'(1);
					end else if (int'(fill_q) < MAX_KEEP) begin
						fill_q <= fill_q + KW'(1);
					end
				end
				ST_EMIT: begin
					if (emit_done) begin
						acc_q  <= '0;
						cnt_q  <= '0;
						ovf_q  <= 1'b0;
						fill_q <= '0;
					end else if (out_load) begin
						rank_q <= rank_q + KW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// new score held for the insertion walk
	always_ff @(posedge clk) begin
		if (state_q == ST_ACC && last_s2) begin
			new_score_q <= acc_sat;
			new_idx_q   <= CIDX_W'(cnt_q);
		end
	end

	// best list: shift one entry down or drop the new score in
	always_ff @(posedge clk) begin
		if (state_q == ST_INS && wr_ok) begin
			if (shift_up) begin
				best_score_q[wr_idx] <= rd_score;
				best_idx_q[wr_idx]   <= rd_cidx;
			end else begin
				best_score_q[wr_idx] <= new_score_q;
				best_idx_q[wr_idx]   <= new_idx_q;
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_rank_q  <= RANK_W'(rank_q);
			out_idx_q   <= rd_cidx;
			out_score_q <= rd_score;
			out_ovf_q   <= ovf_q;
			out_last_q  <= (rank_q + KW'(1)) == n_eff;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {7'b0, out_ovf_q, out_score_q, out_idx_q, out_rank_q};

	// results only come from the readout sequencer
	a_out_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_EMIT))
		else $error("result appeared outside readout");

	// list fill never exceeds its capacity
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(fill_q) <= MAX_KEEP)
		else $error("best list overfilled");

	// insertion walk starts at or below the fill level
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INS) |-> (ins_i_q <= fill_q))
		else $error("insertion walk beyond fill level");

	// candidate counter saturates at the numbering limit
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(cnt_q) <= MAX_CANDIDATES)
		else $error("candidate counter beyond limit");

endmodule

`default_nettype wire
